[rtl/afcl_pkg.sv]
package afcl_pkg;

    localparam int DIM_W     = 15;
    localparam int MODE_W    = 2;
    localparam int NUM_W     = 2 * DIM_W;
    localparam int N_CELLS   = NUM_W;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_DIM   = 16384;

    typedef logic [DIM_W-1:0]     t_dim;
    typedef logic [NUM_W-1:0]     t_num;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_STRETCH = 2'd0;
    localparam t_mode MODE_CROP    = 2'd1;
    localparam t_mode MODE_FIT     = 2'd2;

    localparam t_cfg_idx REG_OUT_WIDTH   = 2'd0;
    localparam t_cfg_idx REG_OUT_HEIGHT  = 2'd1;
    localparam t_cfg_idx REG_ASPECT_MODE = 2'd2;

    localparam t_dim  OUT_WIDTH_RST   = 15'd1920;
    localparam t_dim  OUT_HEIGHT_RST  = 15'd1080;
    localparam t_mode ASPECT_MODE_RST = MODE_FIT;

    // one lane of the restoring divider: partial remainder, numerator bits
    // shifting out while quotient bits shift in, and the divisor
    typedef struct packed {
        t_dim rem;
        t_num nq;
        t_dim dvs;
    } t_div_lane;

    typedef struct packed {
        t_div_lane lane_a;
        t_div_lane lane_b;
        logic      bad;
        t_dim      src_w;
        t_dim      src_h;
    } t_cell;

    typedef struct packed {
        logic  bad;
        t_mode mode;
        t_dim  src_w;
        t_dim  src_h;
        t_dim  fit_w;
        t_dim  fit_h;
        t_dim  span_x;
        t_dim  span_y;
    } t_sel;

    typedef struct packed {
        t_dim crop_left;
        t_dim crop_top;
        t_dim crop_right;
        t_dim crop_bottom;
        t_dim place_left;
        t_dim place_top;
        t_dim place_right;
        t_dim place_bottom;
        logic bad_size;
    } t_result;

endpackage

[rtl/aspect_fit_crop_layout_core.sv]
// pipeline from an accepted input beat to its result beat: 1 product
//   stage, 30 divider cells, 1 select stage, 1 output register
// throughput: one beat per cycle while no result beat is stuck at the
//   output, as the 30-cell divider chain retires one quotient bit per cell
// reset: synchronous active low; clears all valid bits and loads the
//   configuration with 1920 x 1080, fit mode
module aspect_fit_crop_layout_core
    import afcl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    // configuration write port
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_dim     i_cfg_data,
    // input channel
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dim     i_src_width,
    input  t_dim     i_src_height,
    // output channel
    output logic     o_valid,
    input  logic     i_stall,
    output t_dim     o_crop_left,
    output t_dim     o_crop_top,
    output t_dim     o_crop_right,
    output t_dim     o_crop_bottom,
    output t_dim     o_place_left,
    output t_dim     o_place_top,
    output t_dim     o_place_right,
    output t_dim     o_place_bottom,
    output logic     o_bad_size
);

    // configuration registers
    t_dim  r_out_width;
    t_dim  r_out_height;
    t_mode r_aspect_mode;

    // whole pipe moves together; it only holds when the output beat is stuck
    logic w_en;
    logic w_accept;

    // product stage
    logic  r_front_valid;
    t_cell r_front;
    t_cell n_front;
    t_num  w_prod_sw_oh;
    t_num  w_prod_sh_ow;
    logic  w_bad;

    // divider chain taps
    logic  w_stage_valid [0:N_CELLS];
    t_cell w_stage_data  [0:N_CELLS];

    // select stage
    logic r_sel_valid;
    t_sel r_sel;
    t_sel n_sel;

    // output register
    logic    r_out_valid;
    t_result r_out;
    t_result w_place;

    assign w_en     = !r_out_valid || !i_stall;
    assign o_stall  = !w_en;
    assign w_accept = i_valid && w_en;

    //------------------------------------------------------------------
    // configuration
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width   <= OUT_WIDTH_RST;
            r_out_height  <= OUT_HEIGHT_RST;
            r_aspect_mode <= ASPECT_MODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OUT_WIDTH:   r_out_width   <= i_cfg_data;
                REG_OUT_HEIGHT:  r_out_height  <= i_cfg_data;
                REG_ASPECT_MODE: r_aspect_mode <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // product stage: cross products and divisor choice per mode
    //------------------------------------------------------------------
    function automatic logic dim_bad(input t_dim d);
        return (d == '0) || (32'(d) > MAX_DIM);
    endfunction

    assign w_prod_sw_oh = t_num'(i_src_width) * t_num'(r_out_height);
    assign w_prod_sh_ow = t_num'(i_src_height) * t_num'(r_out_width);
    assign w_bad = dim_bad(i_src_width) || dim_bad(i_src_height) ||
                   dim_bad(r_out_width) || dim_bad(r_out_height);

    always_comb begin
        n_front            = '0;
        n_front.bad        = w_bad;
        n_front.src_w      = i_src_width;
        n_front.src_h      = i_src_height;
        if (r_aspect_mode == MODE_CROP) begin
            // lane a: source-width-limited crop height, lane b: crop width
            n_front.lane_a.nq  = w_prod_sw_oh;
            n_front.lane_a.dvs = r_out_width;
            n_front.lane_b.nq  = w_prod_sh_ow;
            n_front.lane_b.dvs = r_out_height;
        end else begin
            // lane a: letterbox height, lane b: pillarbox width
            n_front.lane_a.nq  = w_prod_sh_ow;
            n_front.lane_a.dvs = i_src_width;
            n_front.lane_b.nq  = w_prod_sw_oh;
            n_front.lane_b.dvs = i_src_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (w_en) begin
            r_front_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_front <= n_front;
        end
    end

    //------------------------------------------------------------------
    // divider chain, one quotient bit per cell for both lanes
    //------------------------------------------------------------------
    assign w_stage_valid[0] = r_front_valid;
    assign w_stage_data[0]  = r_front;

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        afcl_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_stage_valid[g]),
            .i_data  (w_stage_data[g]),
            .o_valid (w_stage_valid[g+1]),
            .o_data  (w_stage_data[g+1])
        );
    end

    //------------------------------------------------------------------
    // select stage: pick the limiting side, round to even, floor of two
    //------------------------------------------------------------------
    function automatic t_dim even_min2(input t_num v);
        t_num e;
        e = v & ~t_num'(1);
        if (e == '0) begin
            return t_dim'(2);
        end
        return e[DIM_W-1:0];
    endfunction

    always_comb begin
        t_cell last;
        t_num  q_a;
        t_num  q_b;
        last        = w_stage_data[N_CELLS];
        q_a         = last.lane_a.nq;
        q_b         = last.lane_b.nq;
        n_sel       = '0;
        n_sel.bad   = last.bad;
        n_sel.mode  = r_aspect_mode;
        n_sel.src_w = last.src_w;
        n_sel.src_h = last.src_h;
        if (r_aspect_mode == MODE_CROP) begin
            n_sel.span_x = last.src_w;
            n_sel.span_y = last.src_h;
            if (q_a > t_num'(last.src_h)) begin
                // source too wide for the output aspect: keep full height
                n_sel.fit_w = even_min2(q_b);
                n_sel.fit_h = even_min2(t_num'(last.src_h));
            end else begin
                n_sel.fit_w = even_min2(t_num'(last.src_w));
                n_sel.fit_h = even_min2(q_a);
            end
        end else begin
            n_sel.span_x = r_out_width;
            n_sel.span_y = r_out_height;
            if (q_a <= t_num'(r_out_height)) begin
                // letterbox: full output width
                n_sel.fit_w = even_min2(t_num'(r_out_width));
                n_sel.fit_h = even_min2(q_a);
            end else begin
                // pillarbox: full output height
                n_sel.fit_w = even_min2(q_b);
                n_sel.fit_h = even_min2(t_num'(r_out_height));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_valid <= 1'b0;
        end else if (w_en) begin
            r_sel_valid <= w_stage_valid[N_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sel <= n_sel;
        end
    end

    //------------------------------------------------------------------
    // centering and rectangle assembly, then the output register
    //------------------------------------------------------------------
    afcl_place u_place (
        .i_sel        (r_sel),
        .i_out_width  (r_out_width),
        .i_out_height (r_out_height),
        .o_result     (w_place)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_sel_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_place;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_crop_left    = r_out.crop_left;
    assign o_crop_top     = r_out.crop_top;
    assign o_crop_right   = r_out.crop_right;
    assign o_crop_bottom  = r_out.crop_bottom;
    assign o_place_left   = r_out.place_left;
    assign o_place_top    = r_out.place_top;
    assign o_place_right  = r_out.place_right;
    assign o_place_bottom = r_out.place_bottom;
    assign o_bad_size     = r_out.bad_size;

`ifndef SYNTH
    // the input side only stalls behind a stuck result beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stuck output beat");

    // a bad size beat carries empty rectangles
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_size) |->
            (o_crop_left == '0 && o_crop_top == '0 && o_crop_right == '0 &&
             o_crop_bottom == '0 && o_place_left == '0 && o_place_top == '0 &&
             o_place_right == '0 && o_place_bottom == '0))
        else $error("bad size beat with nonzero rectangle");

    // lane a of the divider chain leaves a proper remainder
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage_valid[N_CELLS] && w_stage_data[N_CELLS].lane_a.dvs != '0) |->
            (w_stage_data[N_CELLS].lane_a.rem < w_stage_data[N_CELLS].lane_a.dvs))
        else $error("divider remainder not below divisor");

    // a beat leaving the divider reaches the select stage in the next cycle when the pipe moves
    a_sel_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_stage_valid[N_CELLS]) |=> r_sel_valid)
        else $error("beat lost between divider and select stage");
`endif

endmodule

[rtl/afcl_div_cell.sv]
module afcl_div_cell
    import afcl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_cell i_data,
    output logic  o_valid,
    output t_cell o_data
);

    logic  r_valid;
    t_cell r_data;
    t_cell n_data;

    // one quotient bit of a restoring division
    function automatic t_div_lane div_step(input t_div_lane in);
        t_div_lane           out;
        logic [DIM_W:0]      shifted;
        logic [DIM_W:0]      diff;
        logic                ge;
        shifted = {in.rem, in.nq[NUM_W-1]};
        diff    = shifted - {1'b0, in.dvs};
        ge      = (shifted >= {1'b0, in.dvs});
        out.rem = ge ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
        out.nq  = {in.nq[NUM_W-2:0], ge};
        out.dvs = in.dvs;
        return out;
    endfunction

    always_comb begin
        n_data        = i_data;
        n_data.lane_a = div_step(i_data.lane_a);
        n_data.lane_b = div_step(i_data.lane_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/afcl_place.sv]
module afcl_place
    import afcl_pkg::*;
(
    input  t_sel    i_sel,
    input  t_dim    i_out_width,
    input  t_dim    i_out_height,
    output t_result o_result
);

    t_dim w_off_x;
    t_dim w_off_y;

    // half the slack, rounded down to even; zero when the part covers the whole
    function automatic t_dim center_off(input t_dim whole, input t_dim part);
        t_dim slack;
        slack = whole - part;
        if (part >= whole) begin
            return '0;
        end
        return (slack >> 1) & ~t_dim'(1);
    endfunction

    assign w_off_x = center_off(i_sel.span_x, i_sel.fit_w);
    assign w_off_y = center_off(i_sel.span_y, i_sel.fit_h);

    always_comb begin
        o_result = '0;
        if (i_sel.bad) begin
            o_result.bad_size = 1'b1;
        end else begin
            case (i_sel.mode)
                MODE_STRETCH: begin
                    o_result.crop_right   = i_sel.src_w;
                    o_result.crop_bottom  = i_sel.src_h;
                    o_result.place_right  = i_out_width;
                    o_result.place_bottom = i_out_height;
                end
                MODE_CROP: begin
                    o_result.crop_left    = w_off_x;
                    o_result.crop_top     = w_off_y;
                    o_result.crop_right   = w_off_x + i_sel.fit_w;
                    o_result.crop_bottom  = w_off_y + i_sel.fit_h;
                    o_result.place_right  = i_out_width;
                    o_result.place_bottom = i_out_height;
                end
                default: begin
                    o_result.crop_right   = i_sel.src_w;
                    o_result.crop_bottom  = i_sel.src_h;
                    o_result.place_left   = w_off_x;
                    o_result.place_top    = w_off_y;
                    o_result.place_right  = w_off_x + i_sel.fit_w;
                    o_result.place_bottom = w_off_y + i_sel.fit_h;
                end
            endcase
        end
    end

endmodule
